@@ sv/philox_pkg.sv @@
// Package: shared constants and types for the Philox 4x32 counter-based generator.
package philox_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] BUMP_A = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] BUMP_B = 32'hBB67AE85;

  // register select is paddr[3] (8-byte register spacing)
  typedef enum logic {
    REG_SEED   = 1'b0,
    REG_OFFSET = 1'b1
  } phx_reg_e;

  // counter block plus the round key it meets in the next round
  typedef struct packed {
    logic [3:0][WORD_W-1:0] ctr;
    logic [WORD_W-1:0]      k0;
    logic [WORD_W-1:0]      k1;
  } phx_state_t;

endpackage

@@ sv/phx_intf.sv @@
// Interfaces: input and result channels of the Philox generator.
interface phx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_index;
  logic        last_of_call;

  modport source (output valid, output element_index, output last_of_call, input ready);
  modport sink   (input valid, input element_index, input last_of_call, output ready);
endinterface

interface phx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_zero;
  logic [31:0] word_one;

  modport source (output valid, output word_zero, output word_one, input ready);
  modport sink   (input valid, input word_zero, input word_one, output ready);
endinterface

@@ sv/phx_round.sv @@
// One registered Philox round: two constant multiplies, XOR mix, key bump.
module phx_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  philox_pkg::phx_state_t state_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output philox_pkg::phx_state_t state_o
);
  import philox_pkg::*;

  logic [2*WORD_W-1:0] prod0;
  logic [2*WORD_W-1:0] prod2;
  phx_state_t          state_d;
  phx_state_t          state_q;
  logic                valid_q;

  assign prod0 = {{WORD_W{1'b0}}, state_i.ctr[0]} * {{WORD_W{1'b0}}, MUL_A};
  assign prod2 = {{WORD_W{1'b0}}, state_i.ctr[2]} * {{WORD_W{1'b0}}, MUL_B};

  always_comb begin
    state_d.ctr[0] = prod2[2*WORD_W-1:WORD_W] ^ state_i.ctr[1] ^ state_i.k0;
    state_d.ctr[1] = prod2[WORD_W-1:0];
    state_d.ctr[2] = prod0[2*WORD_W-1:WORD_W] ^ state_i.ctr[3] ^ state_i.k1;
    state_d.ctr[3] = prod0[WORD_W-1:0];
    state_d.k0     = state_i.k0 + BUMP_A;
    state_d.k1     = state_i.k1 + BUMP_B;
  end

  // stage takes a new item when empty or when its current item moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

@@ sv/phx_cfg.sv @@
// Configuration registers: seed and the running call offset, APB write/read.
module phx_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [philox_pkg::PADDR_W-1:0]      paddr,
  input  logic [philox_pkg::PDATA_W-1:0]      pwdata,
  output logic [philox_pkg::PDATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                bump_i,
  output logic [philox_pkg::WORD_W-1:0]       offset_o,
  output logic [2*philox_pkg::WORD_W-1:0]     seed_o
);
  import philox_pkg::*;

  logic                wr_en;
  phx_reg_e            reg_sel;
  logic [2*WORD_W-1:0] seed_d, seed_q;
  logic [WORD_W-1:0]   offset_d, offset_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = phx_reg_e'(paddr[3]);

  always_comb begin
    seed_d   = seed_q;
    offset_d = bump_i ? offset_q + 1'b1 : offset_q;
    if (wr_en) begin
      case (reg_sel)
        REG_SEED:   seed_d   = pwdata;
        REG_OFFSET: offset_d = pwdata[WORD_W-1:0];
        default:    seed_d   = seed_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SEED:   prdata = seed_q;
      REG_OFFSET: prdata = {{(PDATA_W-WORD_W){1'b0}}, offset_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      offset_q <= '0;
    end else begin
      seed_q   <= seed_d;
      offset_q <= offset_d;
    end
  end

  assign offset_o = offset_q;
  assign seed_o   = seed_q;

  a_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_i && !(wr_en && reg_sel == REG_OFFSET) |=> offset_q == $past(offset_q) + 1'b1)
    else $error("call offset did not advance after last item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bump_i && !wr_en |=> $stable(offset_q) && $stable(seed_q))
    else $error("config state changed without write or last item");

  a_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && reg_sel == REG_SEED |=> seed_q == $past(pwdata))
    else $error("seed write lost");

endmodule

@@ sv/philox_counter_rng_core.sv @@
// Top level: Philox 4x32 counter-based generator, one round per pipeline stage.
// Each accepted item passes through the round stage registers in order; the last is the output register.
// Throughput: one item per cycle while out_o.ready holds; each round stage holds two 32x32 multipliers.
// Stalls: each stage has its own valid bit, so bubbles fill while the output waits.
// Reset (async, active low): clears stage valid bits, seed and call offset to zero.
module philox_counter_rng_core #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  phx_in_if.sink                             in_i,
  phx_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [philox_pkg::PADDR_W-1:0]     paddr,
  input  logic [philox_pkg::PDATA_W-1:0]     pwdata,
  output logic [philox_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready
);
  import philox_pkg::*;

  // link r feeds round stage r; link ROUND_COUNT is the result register
  phx_state_t          link_state [ROUND_COUNT+1];
  logic                link_valid [ROUND_COUNT+1];
  logic                link_ready [ROUND_COUNT+1];

  logic                in_fire;
  logic [WORD_W-1:0]   call_offset;
  logic [2*WORD_W-1:0] seed;

  // offset advances once per accepted item flagged last of its call, unless an APB offset write lands then
  assign in_fire = in_i.valid && in_i.ready;

  phx_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bump_i   (in_fire && in_i.last_of_call),
    .offset_o (call_offset),
    .seed_o   (seed)
  );

  // Counter block is (offset, 0, index, 0); the key is the seed halves.
  // The counter is sampled at accept, so the item sees the pre-increment offset.
  always_comb begin
    link_state[0].ctr[0] = call_offset;
    link_state[0].ctr[1] = '0;
    link_state[0].ctr[2] = in_i.element_index;
    link_state[0].ctr[3] = '0;
    link_state[0].k0     = seed[WORD_W-1:0];
    link_state[0].k1     = seed[2*WORD_W-1:WORD_W];
  end

  assign link_valid[0] = in_i.valid;
  assign in_i.ready    = link_ready[0];

  // Each stage carries its own key copy, bumped by the Weyl constants,
  // so no per-round key table is needed.
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    phx_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[r]),
      .ready_o (link_ready[r]),
      .state_i (link_state[r]),
      .valid_o (link_valid[r+1]),
      .ready_i (link_ready[r+1]),
      .state_o (link_state[r+1])
    );
  end

  // last round's register is the output register; words 0 and 1 are the result
  assign link_ready[ROUND_COUNT] = out_o.ready;
  assign out_o.valid             = link_valid[ROUND_COUNT];
  assign out_o.word_zero         = link_state[ROUND_COUNT].ctr[0];
  assign out_o.word_one          = link_state[ROUND_COUNT].ctr[1];

endmodule
